// ----- design/bfna_pkg.sv -----
// shared types and constants of the best-fit node allocator
package bfna_pkg;

  localparam int NODE_COUNT  = 16;
  localparam int BLOCK_COUNT = 256;
  localparam int UNDO_DEPTH  = 16;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int BLOCK_W     = $clog2(BLOCK_COUNT);
  localparam int UNDO_W      = $clog2(UNDO_DEPTH);
  localparam int FILL_W      = $clog2(UNDO_DEPTH + 1);
  localparam int CAP_W       = 24;

  typedef enum logic [2:0] {
    OP_ADD_NODE = 3'd0, OP_ALLOC = 3'd1, OP_MOVE = 3'd2, OP_UNDO = 3'd3,
    OP_ACCESS = 3'd4, OP_QUERY_NODE = 3'd5, OP_QUERY_BLOCK = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NODE_EXISTS = 3'd1, ST_NODE_MISSING = 3'd2,
    ST_BLOCK_EXISTS = 3'd3, ST_BLOCK_MISSING = 3'd4, ST_NO_ROOM = 3'd5,
    ST_DEST_SHORT = 3'd6, ST_NO_UNDO = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_EXEC, S_UNDO_RD, S_UNDO_EX, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  node_index;
    logic [7:0]  block_index;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         placed_node;
    logic signed [23:0] capacity_value;
    logic [15:0]        access_count;
    logic [7:0]         undone_block;
  } out_item_t;

  // best-fit search handshake between sequencer and scan unit
  typedef struct packed {
    logic        go;
    logic [15:0] size;
  } scan_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [NODE_W-1:0] best;
  } scan_rsp_t;

endpackage

// ----- design/bfna_scan.sv -----
// best-fit scan over the node table with one shared comparator
module bfna_scan (
  input  logic                                      clk,
  input  logic                                      rst,
  input  bfna_pkg::scan_req_t                       req,
  input  logic [bfna_pkg::NODE_COUNT-1:0]           present,
  input  logic [bfna_pkg::NODE_COUNT-1:0][23:0]     free,
  output bfna_pkg::scan_rsp_t                       rsp
);
  import bfna_pkg::*;

  logic                     running;
  logic [NODE_W:0]          idx;
  logic                     found;
  logic [NODE_W-1:0]        best;
  logic signed [CAP_W:0]    best_left;
  logic signed [CAP_W:0]    left;
  logic                     fits;
  logic [NODE_W-1:0]        pos;

  assign pos  = idx[NODE_W-1:0];
  assign left = {free[pos][CAP_W-1], free[pos]} - $signed({9'd0, req.size});
  assign fits = present[pos] && !left[CAP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      rsp     <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go && !running) begin
        running <= 1'b1;
        idx     <= '0;
        found   <= 1'b0;
      end else if (running) begin
        if (fits && (!found || left < best_left)) begin
          found     <= 1'b1;
          best      <= pos;
          best_left <= left;
        end
        if (idx == (NODE_W+1)'(NODE_COUNT - 1)) begin
          running   <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= found || fits;
          rsp.best  <= (fits && (!found || left < best_left)) ? pos : best;
        end
        idx <= idx + 1'b1;
      end
    end
  end
endmodule

// ----- design/best_fit_node_allocator_top.sv -----
// top level: tables, undo stack and operation sequencer
//
// command channel: drive in_item with start high while busy is low; the item
// is taken on that edge and busy rises on the next cycle.
// each item yields exactly one result on out_item, marked by done for one
// cycle; the receiver cannot stall, so the result must be taken then.
// an allocate runs the best-fit scan, which walks the 16 node entries one per
// cycle through a single comparator; undo goes through a stack memory read
// and an update step; every other op passes read, execute and done states.
// one item is in work at a time; busy is already low in the done cycle, so
// the next item can be taken at the edge that ends it.
// reset (rst, synchronous) clears node and block tables at once through
// per-entry valid bits and empties the undo stack; no clearing pass.
// block attributes live in memories read one entry per item; the node table
// sits in flip-flops so the scan can reach every entry.
// op code 7 answers ok with all fields zero.
module best_fit_node_allocator_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bfna_pkg::in_item_t   in_item,
  output logic                 busy,
  output logic                 done,
  output bfna_pkg::out_item_t  out_item
);
  import bfna_pkg::*;

  state_t state, state_next;
  in_item_t cur;

  logic [NODE_COUNT-1:0]             node_present;
  logic [NODE_COUNT-1:0][CAP_W-1:0]  node_free;
  logic [BLOCK_COUNT-1:0]            block_present;

  logic [15:0]       size_mem [BLOCK_COUNT];
  logic [NODE_W-1:0] home_mem [BLOCK_COUNT];
  logic [15:0]       hits_mem [BLOCK_COUNT];
  logic [BLOCK_W+2*NODE_W-1:0] undo_mem [UNDO_DEPTH];

  logic [15:0]       rd_size;
  logic [NODE_W-1:0] rd_home;
  logic [15:0]       rd_hits;
  logic [BLOCK_W+2*NODE_W-1:0] rd_undo;
  logic [FILL_W-1:0] undo_fill;
  logic [UNDO_W-1:0] undo_base;

  logic [BLOCK_W-1:0] rd_addr;
  logic               blk_ok, node_ok;
  logic [BLOCK_W-1:0] u_blk;
  logic [NODE_W-1:0]  u_from, u_to;

  scan_req_t scan_req;
  scan_rsp_t scan_rsp;

  bfna_scan u_scan (
    .clk(clk), .rst(rst), .req(scan_req),
    .present(node_present), .free(node_free), .rsp(scan_rsp)
  );

  assign {u_blk, u_from, u_to} = rd_undo;
  assign rd_addr = (state == S_UNDO_EX) ? u_blk : cur.block_index;
  assign blk_ok  = block_present[cur.block_index];
  assign node_ok = node_present[cur.node_index];

  always_ff @(posedge clk) begin
    rd_size <= size_mem[rd_addr];
    rd_home <= home_mem[rd_addr];
    rd_hits <= hits_mem[rd_addr];
    // hold the popped entry through the update cycle
    if (state != S_UNDO_EX)
      rd_undo <= undo_mem[UNDO_W'(undo_base + UNDO_W'(undo_fill - 1'b1))];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = S_READ;
      S_READ: begin
        if (cur.op == OP_ALLOC && blk_ok == 1'b0) state_next = S_SCAN;
        else if (cur.op == OP_UNDO && undo_fill != '0) state_next = S_UNDO_RD;
        else state_next = S_EXEC;
      end
      S_SCAN:    if (scan_rsp.done) state_next = S_EXEC;
      S_UNDO_RD: state_next = S_UNDO_EX;
      S_UNDO_EX: state_next = S_DONE;
      S_EXEC:    state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy = (state != S_IDLE);
    scan_req.go   = (state == S_READ) && cur.op == OP_ALLOC && !blk_ok;
    scan_req.size = cur.amount;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      node_present  <= '0;
      block_present <= '0;
      undo_fill     <= '0;
      undo_base     <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_IDLE && start) begin
        cur      <= in_item;
        out_item <= '0;
      end
      if (state == S_SCAN && scan_rsp.done && !scan_rsp.found)
        out_item.status <= ST_NO_ROOM;
      if (state == S_SCAN && scan_rsp.done && scan_rsp.found) begin
        node_free[scan_rsp.best] <= node_free[scan_rsp.best] - CAP_W'(cur.amount);
        block_present[cur.block_index] <= 1'b1;
        size_mem[cur.block_index] <= cur.amount;
        home_mem[cur.block_index] <= scan_rsp.best;
        hits_mem[cur.block_index] <= '0;
        out_item.placed_node <= scan_rsp.best;
      end
      if (state == S_READ && cur.op == OP_ALLOC && blk_ok)
        out_item.status <= ST_BLOCK_EXISTS;
      if (state == S_READ && cur.op == OP_UNDO && undo_fill == '0)
        out_item.status <= ST_NO_UNDO;
      if (state == S_EXEC) begin
        case (cur.op)
          OP_ADD_NODE: begin
            if (node_ok) out_item.status <= ST_NODE_EXISTS;
            else begin
              node_present[cur.node_index] <= 1'b1;
              node_free[cur.node_index]    <= CAP_W'(cur.amount);
            end
          end
          OP_MOVE: begin
            if (!blk_ok) out_item.status <= ST_BLOCK_MISSING;
            else if (!node_ok) out_item.status <= ST_NODE_MISSING;
            else if ($signed(node_free[cur.node_index]) <
                     $signed({8'd0, rd_size})) out_item.status <= ST_DEST_SHORT;
            else begin
              if (rd_home != cur.node_index) begin
                node_free[rd_home] <= node_free[rd_home] + CAP_W'(rd_size);
                node_free[cur.node_index] <= node_free[cur.node_index]
                                             - CAP_W'(rd_size);
              end
              undo_mem[UNDO_W'(undo_base + UNDO_W'(undo_fill))] <=
                {cur.block_index, rd_home, cur.node_index};
              if (undo_fill == FILL_W'(UNDO_DEPTH)) undo_base <= undo_base + 1'b1;
              else undo_fill <= undo_fill + 1'b1;
              home_mem[cur.block_index] <= cur.node_index;
              out_item.placed_node  <= cur.node_index;
              out_item.access_count <= rd_hits;
            end
          end
          OP_ACCESS: begin
            if (!blk_ok) out_item.status <= ST_BLOCK_MISSING;
            else begin
              if (rd_hits != 16'hFFFF) hits_mem[cur.block_index] <= rd_hits + 1'b1;
              out_item.access_count <= (rd_hits != 16'hFFFF) ? rd_hits + 1'b1 : rd_hits;
              out_item.placed_node  <= rd_home;
            end
          end
          OP_QUERY_NODE: begin
            if (!node_ok) out_item.status <= ST_NODE_MISSING;
            else out_item.capacity_value <= node_free[cur.node_index];
          end
          OP_QUERY_BLOCK: begin
            if (!blk_ok) out_item.status <= ST_BLOCK_MISSING;
            else begin
              out_item.capacity_value <= {8'd0, rd_size};
              out_item.placed_node    <= rd_home;
              out_item.access_count   <= rd_hits;
            end
          end
          default: ;
        endcase
      end
      // pop happens in S_UNDO_RD; the block data read addressed in S_UNDO_EX lands in S_DONE
      if (state == S_UNDO_RD) undo_fill <= undo_fill - 1'b1;
      if (state == S_UNDO_EX) begin
        out_item.placed_node  <= u_from;
        out_item.undone_block <= u_blk;
      end
      if (state == S_DONE && cur.op == OP_UNDO && out_item.status == ST_OK &&
          block_present[out_item.undone_block]) begin
        if (u_to != u_from) begin
          node_free[u_to]   <= node_free[u_to] + CAP_W'(rd_size);
          node_free[u_from] <= node_free[u_from] - CAP_W'(rd_size);
        end
        home_mem[u_blk]       <= u_from;
        out_item.access_count <= rd_hits;
      end
      if (state == S_DONE) done <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    undo_fill <= FILL_W'(UNDO_DEPTH)) else $error("undo fill out of range");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item not taken");
`endif
endmodule

// ----- bench/tb_best_fit_node_allocator_top.sv -----
// testbench for the best-fit node allocator: scoreboard class, directed and random items
module tb_best_fit_node_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfna_pkg::*;

  class alloc_scoreboard;
    logic              node_on [NODE_COUNT];
    logic [CAP_W-1:0]  node_room [NODE_COUNT];
    logic              blk_on [BLOCK_COUNT];
    logic [15:0]       blk_size [BLOCK_COUNT];
    logic [3:0]        blk_node [BLOCK_COUNT];
    logic [15:0]       blk_hits [BLOCK_COUNT];
    logic [7:0]        log_blk [UNDO_DEPTH];
    logic [3:0]        log_from [UNDO_DEPTH];
    logic [3:0]        log_to [UNDO_DEPTH];
    int                log_fill;
    out_item_t         want_q[$];
    int                mismatches;
    int                items_seen;
    int                results_seen;
    int                op_seen [8];

    function new();
      for (int i = 0; i < NODE_COUNT; i++) begin
        node_on[i] = 0;
        node_room[i] = '0;
      end
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        blk_on[i] = 0;
        blk_size[i] = '0;
        blk_node[i] = '0;
        blk_hits[i] = '0;
      end
      for (int i = 0; i < 8; i++) op_seen[i] = 0;
      log_fill = 0;
      mismatches = 0;
      items_seen = 0;
      results_seen = 0;
    endfunction

    // free capacity as a signed number
    function int room_of(int n);
      return int'($signed(node_room[n]));
    endfunction

    function void note_item(in_item_t it);
      out_item_t e;
      int        best;
      int        best_left;
      int        left;
      int        n;
      int        b;
      int        amt;
      e = '0;
      n = int'(it.node_index);
      b = int'(it.block_index);
      amt = int'(it.amount);
      items_seen++;
      op_seen[it.op]++;
      case (op_t'(it.op))
        OP_ADD_NODE: begin
          if (node_on[n]) e.status = ST_NODE_EXISTS;
          else begin
            node_on[n] = 1;
            node_room[n] = CAP_W'(amt);
          end
        end
        OP_ALLOC: begin
          if (blk_on[b]) e.status = ST_BLOCK_EXISTS;
          else begin
            best = -1;
            best_left = 0;
            for (int i = 0; i < NODE_COUNT; i++) begin
              if (node_on[i] && room_of(i) >= amt) begin
                left = room_of(i) - amt;
                if (best < 0 || left < best_left) begin
                  best = i;
                  best_left = left;
                end
              end
            end
            if (best < 0) e.status = ST_NO_ROOM;
            else begin
              node_room[best] = node_room[best] - CAP_W'(amt);
              blk_on[b] = 1;
              blk_size[b] = 16'(amt);
              blk_node[b] = 4'(best);
              blk_hits[b] = '0;
              e.placed_node = 4'(best);
            end
          end
        end
        OP_MOVE: begin
          if (!blk_on[b]) e.status = ST_BLOCK_MISSING;
          else if (!node_on[n]) e.status = ST_NODE_MISSING;
          else if (room_of(n) < int'(blk_size[b])) e.status = ST_DEST_SHORT;
          else begin
            node_room[blk_node[b]] = node_room[blk_node[b]] + CAP_W'(blk_size[b]);
            node_room[n] = node_room[n] - CAP_W'(blk_size[b]);
            // full log drops its oldest entry
            if (log_fill >= UNDO_DEPTH) begin
              for (int i = 0; i < UNDO_DEPTH - 1; i++) begin
                log_blk[i] = log_blk[i+1];
                log_from[i] = log_from[i+1];
                log_to[i] = log_to[i+1];
              end
              log_fill = UNDO_DEPTH - 1;
            end
            log_blk[log_fill] = 8'(b);
            log_from[log_fill] = blk_node[b];
            log_to[log_fill] = 4'(n);
            log_fill++;
            blk_node[b] = 4'(n);
            e.placed_node = 4'(n);
            e.access_count = blk_hits[b];
          end
        end
        OP_UNDO: begin
          if (log_fill == 0) e.status = ST_NO_UNDO;
          else begin
            log_fill--;
            b = int'(log_blk[log_fill]);
            if (blk_on[b]) begin
              // no room check here, capacity may wrap negative
              node_room[log_to[log_fill]] = node_room[log_to[log_fill]]
                                            + CAP_W'(blk_size[b]);
              node_room[log_from[log_fill]] = node_room[log_from[log_fill]]
                                              - CAP_W'(blk_size[b]);
              blk_node[b] = log_from[log_fill];
              e.access_count = blk_hits[b];
            end
            e.placed_node = log_from[log_fill];
            e.undone_block = 8'(b);
          end
        end
        OP_ACCESS: begin
          if (!blk_on[b]) e.status = ST_BLOCK_MISSING;
          else begin
            if (blk_hits[b] != 16'hffff) blk_hits[b]++;
            e.access_count = blk_hits[b];
            e.placed_node = blk_node[b];
          end
        end
        OP_QUERY_NODE: begin
          if (!node_on[n]) e.status = ST_NODE_MISSING;
          else e.capacity_value = node_room[n];
        end
        OP_QUERY_BLOCK: begin
          if (!blk_on[b]) e.status = ST_BLOCK_MISSING;
          else begin
            e.capacity_value = CAP_W'(blk_size[b]);
            e.placed_node = blk_node[b];
            e.access_count = blk_hits[b];
          end
        end
        default: ;
      endcase
      want_q = {want_q, e};
    endfunction

    function void check_result(out_item_t got);
      out_item_t w;
      results_seen++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      w = want_q.pop_front();
      if (got.status !== w.status || got.placed_node !== w.placed_node ||
          got.capacity_value !== w.capacity_value ||
          got.access_count !== w.access_count || got.undone_block !== w.undone_block) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected st=%0d node=%0d cap=%0d hits=%0d undone=%0d",
                   w.status, w.placed_node, w.capacity_value, w.access_count,
                   w.undone_block);
          $display("          got st=%0d node=%0d cap=%0d hits=%0d undone=%0d",
                   got.status, got.placed_node, got.capacity_value,
                   got.access_count, got.undone_block);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      done;
  out_item_t out_item;
  int        idle_cycles;
  alloc_scoreboard sb;

  best_fit_node_allocator_top u_top (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else begin
      if (start && !busy) sb.note_item(in_item);
      if (done) sb.check_result(out_item);
      if ((start && !busy) || done) idle_cycles <= 0;
      else if (idle_cycles >= 3000) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input op_t op, input int n, input int b, input int amt,
                           input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_item <= '{op: op, node_index: n[3:0], block_index: b[7:0], amount: amt[15:0]};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic int draw_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 65535);
    if (r < 4) return 0;
    return $urandom_range(0, 4095);
  endfunction

  initial begin
    int r;
    int n;
    int b;
    sb = new();
    rst <= 1;
    start <= 0;
    in_item <= '0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: empty tables, extremes, every op and error path
    send_item(OP_QUERY_NODE, 0, 0, 0);
    send_item(OP_UNDO, 0, 0, 0);
    send_item(OP_ALLOC, 0, 0, 1);
    send_item(OP_ACCESS, 0, 7, 0);
    send_item(OP_ADD_NODE, 0, 0, 65535);
    send_item(OP_ADD_NODE, 0, 0, 100);
    send_item(OP_ADD_NODE, 15, 255, 0);
    send_item(OP_ALLOC, 0, 0, 0);
    send_item(OP_ALLOC, 3, 255, 65535);
    send_item(OP_ALLOC, 0, 255, 5);
    send_item(OP_ALLOC, 0, 1, 1);
    send_item(OP_MOVE, 3, 0, 0);
    send_item(OP_MOVE, 15, 255, 0);
    send_item(OP_MOVE, 15, 0, 0);
    send_item(OP_MOVE, 15, 77, 0);
    send_item(OP_ADD_NODE, 5, 0, 40);
    send_item(OP_ALLOC, 0, 9, 30);
    send_item(OP_MOVE, 0, 9, 0);
    // allocate that fits no node, then undo the one logged move and query node 5
    send_item(OP_ALLOC, 0, 10, 40);
    send_item(OP_UNDO, 0, 0, 0);
    send_item(OP_QUERY_NODE, 5, 0, 0);
    send_item(OP_ALLOC, 0, 11, 0);
    send_item(OP_QUERY_BLOCK, 0, 9, 0);
    send_item(OP_NONE, 15, 255, 65535);
    send_item(OP_UNDO, 0, 0, 0);

    // burst of accesses to one block, back to back
    for (int i = 0; i < 40; i++) send_item(OP_ACCESS, 0, 255, 0, 1'b1);
    send_item(OP_QUERY_BLOCK, 0, 255, 0);

    // random mix, mostly operations that reach live blocks and nodes
    for (int i = 0; i < 1150; i++) begin
      r = $urandom_range(0, 99);
      n = $urandom_range(0, 15);
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
      if (r < 5) send_item(OP_ADD_NODE, n, b, $urandom_range(0, 65535));
      else if (r < 30) send_item(OP_ALLOC, n, b, draw_size());
      else if (r < 52) send_item(OP_MOVE, n, b, $urandom_range(0, 65535));
      else if (r < 64) send_item(OP_UNDO, n, b, $urandom_range(0, 65535));
      else if (r < 76) send_item(OP_ACCESS, n, b, $urandom_range(0, 65535));
      else if (r < 86) send_item(OP_QUERY_NODE, n, b, $urandom_range(0, 65535));
      else if (r < 97) send_item(OP_QUERY_BLOCK, n, b, $urandom_range(0, 65535));
      else send_item(OP_NONE, n, b, $urandom_range(0, 65535));
    end
    start <= 0;

    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d items and %0d results: %0d allocates, %0d moves, %0d undos",
             sb.items_seen, sb.results_seen, sb.op_seen[OP_ALLOC], sb.op_seen[OP_MOVE],
             sb.op_seen[OP_UNDO]);
    $display("mismatches: %0d, results outstanding: %0d", sb.mismatches, sb.want_q.size());
    if (sb.mismatches == 0 && sb.want_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
design/bfna_pkg.sv
design/bfna_scan.sv
design/best_fit_node_allocator_top.sv
bench/tb_best_fit_node_allocator_top.sv
